/* hdl/serial_image_load_framer_unit_assert.svh */
// ----------------------------------------------------------------------------
// serial image load framer assertion macros
// concurrent checks that can be compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef SERIAL_IMAGE_LOAD_FRAMER_UNIT_ASSERT_SVH
`define SERIAL_IMAGE_LOAD_FRAMER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled in reset
`define SILF_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("framer check failed");

// next-cycle implication, disabled in reset
`define SILF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("framer check failed");

`else

`define SILF_ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define SILF_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

/* hdl/silf_pkg.sv */
// ----------------------------------------------------------------------------
// silf_pkg
// types and constants of the serial image load framer
// ----------------------------------------------------------------------------
`default_nettype none

package silf_pkg;

    // payload length and offset width
    localparam int LENGTH_BITS = 24;
    localparam logic [31:0] LENGTH_MAX = 32'((64'd1 << LENGTH_BITS) - 64'd1);

    // configuration register width
    localparam int MAXLEN_W = 24;
    localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = '1;

    // frame magic "FWLD"
    localparam logic [7:0] CHAR_F = 8'h46;
    localparam logic [7:0] CHAR_W = 8'h57;
    localparam logic [7:0] CHAR_L = 8'h4C;
    localparam logic [7:0] CHAR_D = 8'h44;
    localparam logic [3:0][7:0] MAGIC = {CHAR_D, CHAR_L, CHAR_W, CHAR_F};

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN,
        PH_DATA,
        PH_SUM,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_BADLEN = 2'd1,
        EV_BADSUM = 2'd2,
        EV_OK     = 2'd3
    } frame_event_t;

endpackage

`default_nettype wire

/* hdl/serial_image_load_framer_unit.sv */
// ----------------------------------------------------------------------------
// serial_image_load_framer_unit
// frame parser for a serial image load: magic, length, payload, checksum
// ----------------------------------------------------------------------------
// Takes one received byte per beat and gives exactly one result beat per
// input beat. The stream is the magic "FWLD", a 4-byte little-endian length,
// the payload, then a 4-byte little-endian checksum equal to the wrapping
// 32-bit sum of the payload. Payload bytes come out as writes at their
// offset; bad length and bad checksum are reported and the hunt restarts;
// a good checksum is reported once and the block then ignores all bytes
// until reset. Throughput is one byte per clock: the frame state is updated
// in the accepting cycle and the result sits in one output register, so a
// byte is taken whenever that register is empty or being drained. The
// result is valid in the cycle after its input beat. The user must write
// max_length only while no result is pending; the block does not enforce it.
`default_nettype none

module serial_image_load_framer_unit (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // configuration
    input  wire logic                         cfg_wr_en,
    input  wire logic [silf_pkg::MAXLEN_W-1:0] cfg_wr_data,
    // byte input
    input  wire logic                         s_valid,
    output      logic                         s_ready,
    input  wire logic [7:0]                   s_rx_byte,
    // result output
    output      logic                         m_valid,
    input  wire logic                         m_ready,
    output      logic                         m_write_enable,
    output      logic [silf_pkg::LENGTH_BITS-1:0] m_write_offset,
    output      logic [7:0]                   m_write_data,
    output      logic [1:0]                   m_frame_event
);

    import silf_pkg::*;

    `include "serial_image_load_framer_unit_assert.svh"

    // frame state
    phase_t                  phase_reg, phase_next;
    logic [1:0]              magic_matched_reg, magic_matched_next;
    logic [1:0]              word_byte_index_reg, word_byte_index_next;
    logic [31:0]             frame_length_reg, frame_length_next;
    logic [LENGTH_BITS-1:0]  payload_index_reg, payload_index_next;
    logic [31:0]             running_sum_reg, running_sum_next;
    logic [31:0]             received_checksum_reg, received_checksum_next;
    logic [MAXLEN_W-1:0]     max_length_reg;

    // result register
    logic                    out_valid_reg;
    logic                    write_enable_reg, write_enable_next;
    logic [LENGTH_BITS-1:0]  write_offset_reg, write_offset_next;
    logic [7:0]              write_data_reg, write_data_next;
    frame_event_t            frame_event_reg, frame_event_next;

    // shared decode
    logic                    in_beat;
    logic [4:0]              byte_shift;
    logic [31:0]             byte_placed;
    logic [31:0]             length_word;
    logic [31:0]             checksum_word;
    logic                    length_bad;
    logic                    word_last;
    logic [LENGTH_BITS-1:0]  payload_index_inc;

    assign s_ready = !out_valid_reg || m_ready;
    assign in_beat = s_valid && s_ready;

    // byte placement into the little-endian words
    assign byte_shift        = {word_byte_index_reg, 3'b000};
    assign byte_placed       = 32'(s_rx_byte) << byte_shift;
    assign length_word       = frame_length_reg | byte_placed;
    assign checksum_word     = received_checksum_reg | byte_placed;
    assign word_last         = (word_byte_index_reg == 2'd3);
    assign payload_index_inc = payload_index_reg + LENGTH_BITS'(1);
    assign length_bad        = (length_word == 32'd0)
                            || (length_word > 32'(max_length_reg))
                            || (length_word > LENGTH_MAX);

    // next frame state
    always_comb begin
        phase_next             = phase_reg;
        magic_matched_next     = magic_matched_reg;
        word_byte_index_next   = word_byte_index_reg;
        frame_length_next      = frame_length_reg;
        payload_index_next     = payload_index_reg;
        running_sum_next       = running_sum_reg;
        received_checksum_next = received_checksum_reg;
        case (phase_reg)
            PH_HUNT: begin
                if (s_rx_byte == MAGIC[magic_matched_reg]) begin
                    if (magic_matched_reg == 2'd3) begin
                        magic_matched_next   = 2'd0;
                        word_byte_index_next = 2'd0;
                        frame_length_next    = 32'd0;
                        phase_next           = PH_LEN;
                    end else begin
                        magic_matched_next = magic_matched_reg + 2'd1;
                    end
                end else begin
                    magic_matched_next = (s_rx_byte == CHAR_F) ? 2'd1 : 2'd0;
                end
            end
            PH_LEN: begin
                frame_length_next = length_word;
                if (word_last) begin
                    word_byte_index_next = 2'd0;
                    if (length_bad) begin
                        phase_next = PH_HUNT;
                    end else begin
                        payload_index_next = '0;
                        running_sum_next   = 32'd0;
                        phase_next         = PH_DATA;
                    end
                end else begin
                    word_byte_index_next = word_byte_index_reg + 2'd1;
                end
            end
            PH_DATA: begin
                running_sum_next   = running_sum_reg + 32'(s_rx_byte);
                payload_index_next = payload_index_inc;
                if (payload_index_inc == frame_length_reg[LENGTH_BITS-1:0]) begin
                    word_byte_index_next   = 2'd0;
                    received_checksum_next = 32'd0;
                    phase_next             = PH_SUM;
                end
            end
            PH_SUM: begin
                received_checksum_next = checksum_word;
                if (word_last) begin
                    word_byte_index_next = 2'd0;
                    phase_next = (checksum_word == running_sum_reg) ? PH_DONE : PH_HUNT;
                end else begin
                    word_byte_index_next = word_byte_index_reg + 2'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // result of the current byte
    always_comb begin
        write_enable_next = 1'b0;
        write_offset_next = '0;
        write_data_next   = 8'd0;
        frame_event_next  = EV_NONE;
        case (phase_reg)
            PH_LEN: begin
                if (word_last && length_bad) begin
                    frame_event_next = EV_BADLEN;
                end
            end
            PH_DATA: begin
                write_enable_next = 1'b1;
                write_offset_next = payload_index_reg;
                write_data_next   = s_rx_byte;
            end
            PH_SUM: begin
                if (word_last) begin
                    frame_event_next = (checksum_word == running_sum_reg) ? EV_OK : EV_BADSUM;
                end
            end
            default: begin
            end
        endcase
    end

    // control and frame state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg             <= PH_HUNT;
            magic_matched_reg     <= 2'd0;
            word_byte_index_reg   <= 2'd0;
            frame_length_reg      <= 32'd0;
            payload_index_reg     <= '0;
            running_sum_reg       <= 32'd0;
            received_checksum_reg <= 32'd0;
            max_length_reg        <= MAXLEN_RESET;
            out_valid_reg         <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_length_reg <= cfg_wr_data;
            end
            if (in_beat) begin
                phase_reg             <= phase_next;
                magic_matched_reg     <= magic_matched_next;
                word_byte_index_reg   <= word_byte_index_next;
                frame_length_reg      <= frame_length_next;
                payload_index_reg     <= payload_index_next;
                running_sum_reg       <= running_sum_next;
                received_checksum_reg <= received_checksum_next;
            end
            if (s_ready) begin
                out_valid_reg <= s_valid;
            end
        end
    end

    // result payload register
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            write_enable_reg <= write_enable_next;
            write_offset_reg <= write_offset_next;
            write_data_reg   <= write_data_next;
            frame_event_reg  <= frame_event_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_write_enable = write_enable_reg;
    assign m_write_offset = write_offset_reg;
    assign m_write_data   = write_data_reg;
    assign m_frame_event  = frame_event_reg;

    // a payload byte always leaves as a write beat
    `SILF_ASSERT_NEXT(a_data_write, aclk, aresetn, in_beat && (phase_reg == PH_DATA), m_valid && m_write_enable)

    // success is reported only when the framer has locked in done
    `SILF_ASSERT_IMPLIES(a_ok_done, aclk, aresetn, m_valid && (m_frame_event == EV_OK), phase_reg == PH_DONE)

    // done holds until reset
    `SILF_ASSERT_NEXT(a_done_sticky, aclk, aresetn, phase_reg == PH_DONE, phase_reg == PH_DONE)

endmodule

`default_nettype wire
